// ===== rtl/bwts_pkg.sv =====
// Package for the bilinear wrap texture sampler.
// Holds store geometry, field widths, operation and register codes, and the command type.
// No dependencies.
package bwts_pkg;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 512;
	localparam int STORE_WORDS   = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS     = $clog2(STORE_WORDS);
	localparam int W_BITS        = $clog2(MAX_WIDTH + 1);
	localparam int H_BITS        = $clog2(MAX_HEIGHT + 1);
	localparam int X_BITS        = $clog2(MAX_WIDTH);
	localparam int Y_BITS        = $clog2(MAX_HEIGHT);

	localparam int INDEX_BITS    = 19;
	localparam int COLOR_BITS    = 32;
	localparam int FRAC_BITS     = 16;
	localparam int CFG_W_BITS    = 11;
	localparam int CFG_H_BITS    = 10;
	localparam int CFG_DATA_BITS = 11;

	localparam int TEX_WIDTH_RESET  = 1024;
	localparam int TEX_HEIGHT_RESET = 512;
	localparam int W_RESET = (TEX_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : TEX_WIDTH_RESET;
	localparam int H_RESET = (TEX_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : TEX_HEIGHT_RESET;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic {
		CFG_TEX_WIDTH  = 1'b0,
		CFG_TEX_HEIGHT = 1'b1
	} cfg_reg_t;

	// One queued command: a texel write (base0 = address) or a four-texel sample.
	typedef struct packed {
		logic                  sample;
		logic [ADDR_BITS-1:0]  base0;
		logic [ADDR_BITS-1:0]  base1;
		logic [X_BITS-1:0]     x0;
		logic [X_BITS-1:0]     x1;
		logic [FRAC_BITS-1:0]  tx;
		logic [FRAC_BITS-1:0]  ty;
		logic [COLOR_BITS-1:0] color;
	} cmd_t;

endpackage

// ===== rtl/bwts_front.sv =====
// Front end: size registers, input transfer, coordinate scaling and neighbor addressing.
// Produces one cmd_t per kept item. Depends on bwts_pkg.
module bwts_front import bwts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [0:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [0:0]               op,
	input  logic [INDEX_BITS-1:0]    texel_index,
	input  logic [COLOR_BITS-1:0]    texel_color,
	input  logic [FRAC_BITS-1:0]     u_frac,
	input  logic [FRAC_BITS-1:0]     v_frac,
	output logic                     cmd_valid,
	input  logic                     cmd_ready,
	output cmd_t                     cmd
);

	localparam int PX_BITS = FRAC_BITS + W_BITS;
	localparam int PY_BITS = FRAC_BITS + H_BITS;
	localparam int PR_BITS = Y_BITS + W_BITS;

	logic [W_BITS-1:0] w_q;
	logic [H_BITS-1:0] h_q;
	logic [31:0]       cfg_wide;
	logic [31:0]       cfg_hwide;
	logic [31:0]       w_next;
	logic [31:0]       h_next;

	logic [PX_BITS-1:0] fx;
	logic [PY_BITS-1:0] fy;
	logic [31:0]        idx_wide;
	logic               keep;
	logic               in_xfer;
	logic               s1_adv;
	logic               s2_adv;

	logic                  s1_v;
	logic                  sample_s1;
	logic [X_BITS-1:0]     x0_s1;
	logic [Y_BITS-1:0]     y0_s1;
	logic [FRAC_BITS-1:0]  tx_s1;
	logic [FRAC_BITS-1:0]  ty_s1;
	logic [ADDR_BITS-1:0]  addr_s1;
	logic [COLOR_BITS-1:0] color_s1;

	logic [W_BITS-1:0] x0p;
	logic [H_BITS-1:0] y0p;
	logic [X_BITS-1:0] x1;
	logic [Y_BITS-1:0] y1;
	logic [PR_BITS-1:0] prod0;
	logic [PR_BITS-1:0] prod1;

	logic s2_v;
	cmd_t cmd_s2;

	// size clamping: zero reads as one, oversize reads as the maximum; height from data[9:0]
	always_comb begin
		cfg_wide  = 32'(cfg_data);
		cfg_hwide = 32'(cfg_data[CFG_H_BITS-1:0]);
		if (cfg_wide == 32'd0) begin
			w_next = 32'd1;
		end else if (cfg_wide > 32'(MAX_WIDTH)) begin
			w_next = 32'(MAX_WIDTH);
		end else begin
			w_next = cfg_wide;
		end
		if (cfg_hwide == 32'd0) begin
			h_next = 32'd1;
		end else if (cfg_hwide > 32'(MAX_HEIGHT)) begin
			h_next = 32'(MAX_HEIGHT);
		end else begin
			h_next = cfg_hwide;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_BITS'(W_RESET);
			h_q <= H_BITS'(H_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TEX_WIDTH:  w_q <= w_next[W_BITS-1:0];
				CFG_TEX_HEIGHT: h_q <= h_next[H_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign s2_adv   = !s2_v || cmd_ready;
	assign s1_adv   = !s1_v || s2_adv;
	assign in_ready = s1_adv;
	assign in_xfer  = in_valid && in_ready;

	assign fx       = PX_BITS'(u_frac) * PX_BITS'(w_q);
	assign fy       = PY_BITS'(v_frac) * PY_BITS'(h_q);
	assign idx_wide = 32'(texel_index);
	assign keep     = (op == OP_SAMPLE) || (idx_wide < 32'(STORE_WORDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (in_xfer) begin
			s1_v <= keep;
		end else if (s2_adv) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_s1 <= (op == OP_SAMPLE);
			x0_s1     <= fx[FRAC_BITS +: X_BITS];
			y0_s1     <= fy[FRAC_BITS +: Y_BITS];
			tx_s1     <= fx[FRAC_BITS-1:0];
			ty_s1     <= fy[FRAC_BITS-1:0];
			addr_s1   <= idx_wide[ADDR_BITS-1:0];
			color_s1  <= texel_color;
		end
	end

	// right and bottom neighbors wrap to column and row zero
	always_comb begin
		x0p   = W_BITS'(x0_s1) + W_BITS'(1);
		y0p   = H_BITS'(y0_s1) + H_BITS'(1);
		x1    = (x0p >= w_q) ? '0 : x0p[X_BITS-1:0];
		y1    = (y0p >= h_q) ? '0 : y0p[Y_BITS-1:0];
		prod0 = PR_BITS'(y0_s1) * PR_BITS'(w_q);
		prod1 = PR_BITS'(y1) * PR_BITS'(w_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_adv) begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && s1_v) begin
			cmd_s2.sample <= sample_s1;
			cmd_s2.base0  <= sample_s1 ? prod0[ADDR_BITS-1:0] : addr_s1;
			cmd_s2.base1  <= prod1[ADDR_BITS-1:0];
			cmd_s2.x0     <= x0_s1;
			cmd_s2.x1     <= x1;
			cmd_s2.tx     <= tx_s1;
			cmd_s2.ty     <= ty_s1;
			cmd_s2.color  <= color_s1;
		end
	end

	assign cmd_valid = s2_v;
	assign cmd       = cmd_s2;

endmodule

// ===== rtl/bwts_cmd_fifo.sv =====
// Command queue between the front end and the texture back end.
// Small register FIFO of cmd_t. Depends on bwts_pkg.
module bwts_cmd_fifo import bwts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int PTR_BITS = $clog2(CMD_DEPTH);
	localparam int CNT_BITS = $clog2(CMD_DEPTH + 1);

	cmd_t                entry_q [CMD_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                push;
	logic                pop;

	assign push_ready = (cnt_q != CNT_BITS'(CMD_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bwts_back.sv =====
// Back end: single-port texture memory, four-read sample sequencer, bilinear blend
// and result buffer. Depends on bwts_pkg.
module bwts_back import bwts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COLOR_BITS-1:0] sampled_color
);

	localparam int OCNT_BITS = $clog2(OUT_DEPTH + 1);
	localparam int OPTR_BITS = $clog2(OUT_DEPTH);

	function automatic logic [23:0] lerp8(logic [7:0] a, logic [7:0] b, logic [15:0] t);
		logic [16:0] wa;
		logic [24:0] s;
		wa = 17'h10000 - 17'(t);
		s  = 25'(wa) * 25'(a) + 25'(t) * 25'(b);
		return s[23:0];
	endfunction

	function automatic logic [7:0] blend8(logic [23:0] a, logic [23:0] b, logic [15:0] t);
		logic [16:0] wa;
		logic [40:0] s;
		wa = 17'h10000 - 17'(t);
		s  = 41'(wa) * 41'(a) + 41'(t) * 41'(b);
		return s[39:32];
	endfunction

	logic [COLOR_BITS-1:0] texel_mem [STORE_WORDS];

	logic                 busy_q;
	logic [1:0]           k_q;
	logic [1:0]           k_sel;
	logic                 room;
	logic                 start;
	logic                 do_load;
	logic                 rd_en;
	logic                 last;
	logic [ADDR_BITS-1:0] rd_base;
	logic [X_BITS-1:0]    rd_x;
	logic [ADDR_BITS-1:0] rd_addr;

	logic [COLOR_BITS-1:0] rd_data_s1;
	logic                  rd_v_s1;
	logic [1:0]            rd_k_s1;
	logic [FRAC_BITS-1:0]  tx_s1;
	logic [FRAC_BITS-1:0]  ty_s1;

	logic [COLOR_BITS-1:0] p0_q;
	logic [3:0][23:0]      h0_q;
	logic [3:0][23:0]      h1_q;
	logic [3:0][23:0]      h_new;
	logic [FRAC_BITS-1:0]  ty_q;
	logic                  blend_v_q;
	logic [COLOR_BITS-1:0] blend_res;

	logic [COLOR_BITS-1:0] out_mem_q [OUT_DEPTH];
	logic [OPTR_BITS-1:0]  out_wr_q;
	logic [OPTR_BITS-1:0]  out_rd_q;
	logic [OCNT_BITS-1:0]  out_cnt_q;
	logic [OCNT_BITS-1:0]  inflight_q;
	logic                  push_out;
	logic                  pop_out;

	// a sample starts only if its result is sure to find a slot
	assign room      = ((OCNT_BITS+1)'(out_cnt_q) + (OCNT_BITS+1)'(inflight_q))
	                   < (OCNT_BITS+1)'(OUT_DEPTH);
	assign start     = !busy_q && cmd_valid && cmd.sample && room;
	assign do_load   = !busy_q && cmd_valid && !cmd.sample;
	assign rd_en     = start || busy_q;
	assign k_sel     = busy_q ? k_q : 2'd0;
	assign last      = busy_q && (k_q == 2'd3);
	assign cmd_ready = do_load || last;

	// read order: top-left, top-right, bottom-left, bottom-right
	assign rd_base = k_sel[1] ? cmd.base1 : cmd.base0;
	assign rd_x    = k_sel[0] ? cmd.x1 : cmd.x0;
	assign rd_addr = rd_base + ADDR_BITS'(rd_x);

	always_ff @(posedge clk) begin
		if (do_load) begin
			texel_mem[cmd.base0] <= cmd.color;
		end else if (rd_en) begin
			rd_data_s1 <= texel_mem[rd_addr];
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			h_new[c]          = lerp8(p0_q[c*8 +: 8], rd_data_s1[c*8 +: 8], tx_s1);
			blend_res[c*8 +: 8] = blend8(h0_q[c], h1_q[c], ty_q);
		end
	end

	assign push_out      = blend_v_q;
	assign out_valid     = (out_cnt_q != '0);
	assign pop_out       = out_valid && out_ready;
	assign sampled_color = out_mem_q[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			k_q        <= 2'd0;
			rd_v_s1    <= 1'b0;
			rd_k_s1    <= 2'd0;
			blend_v_q  <= 1'b0;
			inflight_q <= '0;
			out_wr_q   <= '0;
			out_rd_q   <= '0;
			out_cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= 2'd1;
			end else if (busy_q) begin
				k_q <= k_q + 2'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			rd_v_s1   <= rd_en;
			rd_k_s1   <= k_sel;
			blend_v_q <= rd_v_s1 && (rd_k_s1 == 2'd3);
			if (start && !push_out) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (push_out && !start) begin
				inflight_q <= inflight_q - 1'b1;
			end
			if (push_out) begin
				out_wr_q <= (out_wr_q == OPTR_BITS'(OUT_DEPTH - 1)) ? '0 : out_wr_q + 1'b1;
			end
			if (pop_out) begin
				out_rd_q <= (out_rd_q == OPTR_BITS'(OUT_DEPTH - 1)) ? '0 : out_rd_q + 1'b1;
			end
			if (push_out && !pop_out) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (pop_out && !push_out) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tx_s1 <= cmd.tx;
			ty_s1 <= cmd.ty;
		end
		if (rd_v_s1) begin
			case (rd_k_s1)
				2'd0: p0_q <= rd_data_s1;
				2'd1: h0_q <= h_new;
				2'd2: p0_q <= rd_data_s1;
				2'd3: begin
					h1_q <= h_new;
					ty_q <= ty_s1;
				end
				default: ;
			endcase
		end
		if (push_out) begin
			out_mem_q[out_wr_q] <= blend_res;
		end
	end

	a_no_overbook: assert property (@(posedge clk) disable iff (!arst_n)
		((OCNT_BITS+1)'(out_cnt_q) + (OCNT_BITS+1)'(inflight_q)) <= (OCNT_BITS+1)'(OUT_DEPTH))
		else $error("result slots overbooked");

	a_push_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		blend_v_q |-> (out_cnt_q != OCNT_BITS'(OUT_DEPTH)))
		else $error("result pushed into full buffer");

	a_last_read_blends: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_v_s1 && (rd_k_s1 == 2'd3)) |=> (blend_v_q && (inflight_q != '0)))
		else $error("fourth texel did not produce a blend");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cmd_valid && cmd.sample))
		else $error("sample command lost while reading");

	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		do_load |-> !busy_q && !start)
		else $error("texel write collides with a read");

endmodule

// ===== rtl/bilinear_wrap_texture_sampler.sv =====
// Bilinear wrap texture sampler: a load item (op 0) writes one 0xAABBGGRR texel at a
// row-major index and gives no result; a sample item (op 1) gives one filtered color.
// Throughput is one load per cycle while no sample reads the memory, set by the single
// port of the texture memory, which a sample reads four times (one texel per cycle).
// The next sample starts only after the last read of the one before. A queue between the
// coordinate front end and the memory back end lets input transfers continue while
// results wait. Only texels that were loaded may be sampled; the store is not cleared.
// Size registers: index 0 width, index 1 height (data[9:0]), clamped to one and the max.
module bilinear_wrap_texture_sampler import bwts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [0:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [0:0]               op,
	input  logic [INDEX_BITS-1:0]    texel_index,
	input  logic [COLOR_BITS-1:0]    texel_color,
	input  logic [FRAC_BITS-1:0]     u_frac,
	input  logic [FRAC_BITS-1:0]     v_frac,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [COLOR_BITS-1:0]    sampled_color
);

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	assign cfg_ready = 1'b1;

	bwts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.texel_index (texel_index),
		.texel_color (texel_color),
		.u_frac      (u_frac),
		.v_frac      (v_frac),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd         (f_cmd)
	);

	bwts_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cmd)
	);

	bwts_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (q_valid),
		.cmd_ready     (q_ready),
		.cmd           (q_cmd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sampled_color (sampled_color)
	);

endmodule
